// File: src/hpss_pkg.sv
// Shared types, codes and the microcode ROM of the hydraulic press step sequencer.
// No dependencies; the top level imports it.
package hpss_pkg;

  // Mode codes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_GUP   = 3'd1;
  localparam logic [2:0] MODE_GDOWN = 3'd2;
  localparam logic [2:0] MODE_WORK  = 3'd3;
  localparam logic [2:0] MODE_ADD   = 3'd4;
  localparam logic [2:0] MODE_RET   = 3'd5;

  // Key codes
  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_GO   = 2'd1;
  localparam logic [1:0] KEY_UP   = 2'd2;
  localparam logic [1:0] KEY_DN   = 2'd3;

  // Service-test codes
  localparam logic [2:0] TST_NONE  = 3'd0;
  localparam logic [2:0] TST_ADD   = 3'd1;
  localparam logic [2:0] TST_RET   = 3'd2;
  localparam logic [2:0] TST_GUP   = 3'd3;
  localparam logic [2:0] TST_GDOWN = 3'd4;

  // Valve masks
  localparam logic [3:0] VLV_MAIN = 4'b0001;
  localparam logic [3:0] VLV_PUP  = 4'b0010;
  localparam logic [3:0] VLV_PDN  = 4'b0100;
  localparam logic [3:0] VLV_DIA  = 4'b1000;

  // Motor commands
  localparam logic [1:0] MOT_STOP = 2'd0;
  localparam logic [1:0] MOT_UP   = 2'd1;
  localparam logic [1:0] MOT_DOWN = 2'd2;

  // Step operations run by the datapath
  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_SUCK,
    UOP_RETURN,
    UOP_SPIT_ADD,
    UOP_SPIT_GUP,
    UOP_SPIT_GDN
  } uop_e;

  // One control word: operation, end of program, clear step at end
  typedef struct packed {
    uop_e op;
    logic last;
    logic clr_step;
  } uword_t;

  // Microcode ROM, addressed by {mode, step}
  function automatic uword_t hpss_ucode(input logic [5:0] addr);
    uword_t w;
    w = '{op: UOP_NOP, last: 1'b1, clr_step: 1'b0};
    unique case (addr)
      {MODE_WORK, 3'd0}:  w = '{op: UOP_SUCK,     last: 1'b0, clr_step: 1'b0};
      {MODE_WORK, 3'd1}:  w = '{op: UOP_SPIT_GDN, last: 1'b0, clr_step: 1'b0};
      {MODE_WORK, 3'd2}:  w = '{op: UOP_SUCK,     last: 1'b0, clr_step: 1'b0};
      {MODE_WORK, 3'd3}:  w = '{op: UOP_SPIT_ADD, last: 1'b0, clr_step: 1'b0};
      {MODE_WORK, 3'd4}:  w = '{op: UOP_RETURN,   last: 1'b0, clr_step: 1'b0};
      {MODE_WORK, 3'd5}:  w = '{op: UOP_SPIT_GUP, last: 1'b0, clr_step: 1'b0};
      {MODE_WORK, 3'd6}:  w = '{op: UOP_SUCK,     last: 1'b1, clr_step: 1'b0};
      {MODE_GUP, 3'd0}:   w = '{op: UOP_SUCK,     last: 1'b0, clr_step: 1'b0};
      {MODE_GUP, 3'd1}:   w = '{op: UOP_SPIT_GUP, last: 1'b1, clr_step: 1'b1};
      {MODE_GDOWN, 3'd0}: w = '{op: UOP_SUCK,     last: 1'b0, clr_step: 1'b0};
      {MODE_GDOWN, 3'd1}: w = '{op: UOP_SPIT_GDN, last: 1'b1, clr_step: 1'b1};
      {MODE_ADD, 3'd0}:   w = '{op: UOP_SUCK,     last: 1'b0, clr_step: 1'b0};
      {MODE_ADD, 3'd1}:   w = '{op: UOP_SPIT_ADD, last: 1'b1, clr_step: 1'b1};
      {MODE_RET, 3'd0}:   w = '{op: UOP_RETURN,   last: 1'b1, clr_step: 1'b1};
      default:            w = '{op: UOP_NOP,      last: 1'b1, clr_step: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// File: src/hydraulic_press_step_sequencer.sv
// Hydraulic press step sequencer: microcoded walk over the press steps per event.
// Depends on hpss_pkg (codes, control word type, microcode ROM).
//
// Usage:
//   The slave stream takes one event item: key code, service-test command and
//   optional fresh limit-switch and sensor words. The master stream returns one
//   item per event: four valve states, motor command, mode and step.
//   An event is first taken in (latch bits, pick the mode), then the microcode
//   runs its steps: a step that ends lets the next step run in the following
//   cycle; the item goes out when a step has not ended, the last step ends or
//   the mode has no step. The full work cycle has seven steps. The single step
//   datapath handles one event at a time; s_axis_tready is high while no event
//   runs. A finished item sits in the output register; the next event is taken
//   while it waits, and that event holds the step that would end it until the
//   output register is free.
//   Reset (rst_ni low) returns to idle mode, step 0, all valves closed, motor
//   stopped, latched words cleared, no item pending.
module hydraulic_press_step_sequencer
  import hpss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] key_code, [4:2] test_cmd, [5] limit_valid, [8:6] limit_bits,
  // [9] sensor_valid, [13:10] sensor_bits, [15:14] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] valve_main, [1] valve_piston_up, [2] valve_piston_down,
  // [3] valve_diaphragm, [5:4] motor_drive, [8:6] mode_out, [11:9] step_out,
  // [15:12] zero
  output logic [15:0] m_axis_tdata
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e      state_q, state_d;
  logic [2:0]  mode_q, mode_d;
  logic [2:0]  step_q, step_d;
  logic        stage_q, stage_d;
  logic [2:0]  lim_q, lim_d;
  logic [3:0]  sen_q, sen_d;
  logic [3:0]  valve_q, valve_d;
  logic [1:0]  motor_q, motor_d;
  logic        kstart_q, kstart_d;
  logic        otvalid_q, otvalid_d;
  logic [15:0] odata_q, odata_d;

  // Input fields
  logic [1:0] in_key;
  logic [2:0] in_test;
  assign in_key  = s_axis_tdata[1:0];
  assign in_test = s_axis_tdata[4:2];

  // Step datapath signals
  uword_t     uw;
  logic [3:0] v_n;
  logic [1:0] m_n;
  logic       fin;
  logic       done;
  logic       lim_up, lim_dn, lim_pist;
  logic       sen_gl, sen_ht, sen_bu;

  assign lim_up   = lim_q[0];
  assign lim_dn   = lim_q[1];
  assign lim_pist = lim_q[2];
  assign sen_gl   = sen_q[0];
  assign sen_ht   = sen_q[1];
  assign sen_bu   = sen_q[2];

  assign uw = hpss_ucode({mode_q, step_q});

  // Run the current step: setup in stage 0, then check the end condition
  always_comb begin
    v_n = valve_q;
    m_n = motor_q;
    fin = 1'b0;
    case (uw.op)
      UOP_SUCK: begin
        if (!stage_q) begin
          if (!lim_dn) m_n = MOT_DOWN;
          v_n = (v_n & ~(VLV_PUP | VLV_PDN | VLV_DIA)) | VLV_MAIN;
        end
        if (lim_dn || kstart_q) begin
          v_n = v_n & ~VLV_MAIN;
          m_n = MOT_STOP;
          fin = 1'b1;
        end
      end
      UOP_RETURN: begin
        if (!stage_q) begin
          if (!lim_dn) begin
            v_n = (v_n & ~(VLV_PDN | VLV_DIA | VLV_MAIN)) | VLV_DIA;
            m_n = MOT_DOWN;
          end else begin
            v_n = v_n | VLV_DIA;
          end
        end
        if (lim_dn || kstart_q) begin
          v_n = v_n & ~VLV_DIA;
          m_n = MOT_STOP;
          fin = 1'b1;
        end
      end
      UOP_SPIT_ADD: begin
        if (!stage_q) begin
          if (!sen_bu || !lim_up) begin
            v_n = (v_n & ~(VLV_PDN | VLV_DIA | VLV_MAIN)) | VLV_DIA;
            m_n = MOT_UP;
          end else begin
            v_n = v_n | VLV_DIA;
          end
        end
        if (sen_bu || lim_up || sen_ht || kstart_q) begin
          m_n = MOT_STOP;
          fin = 1'b1;
        end
      end
      UOP_SPIT_GUP: begin
        if (!stage_q && !lim_up) begin
          v_n = (v_n & ~(VLV_PDN | VLV_DIA | VLV_MAIN)) | VLV_PUP;
          m_n = MOT_UP;
        end
        if (lim_up || lim_pist) begin
          v_n = v_n & ~VLV_PUP;
          m_n = MOT_STOP;
          fin = 1'b1;
        end
      end
      UOP_SPIT_GDN: begin
        if (!stage_q && (!sen_gl || !lim_up)) begin
          v_n = (v_n & ~(VLV_PDN | VLV_DIA | VLV_MAIN)) | VLV_PDN;
          m_n = MOT_UP;
        end
        if (sen_gl || lim_up || kstart_q) begin
          m_n = MOT_STOP;
          fin = 1'b1;
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // Sequencer and handshake control
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    step_d    = step_q;
    stage_d   = stage_q;
    lim_d     = lim_q;
    sen_d     = sen_q;
    valve_d   = valve_q;
    motor_d   = motor_q;
    kstart_d  = kstart_q;
    odata_d   = odata_q;
    otvalid_d = otvalid_q && !m_axis_tready;
    done      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          // Latch fresh words, pick a mode while idle
          if (s_axis_tdata[5]) lim_d = s_axis_tdata[8:6];
          if (s_axis_tdata[9]) sen_d = s_axis_tdata[13:10];
          kstart_d = (in_key == KEY_GO) && (mode_q != MODE_IDLE);
          if (mode_q == MODE_IDLE) begin
            step_d  = 3'd0;
            stage_d = 1'b0;
            if (in_key != KEY_NONE) begin
              if (in_key == KEY_GO)      mode_d = MODE_WORK;
              else if (in_key == KEY_UP) mode_d = MODE_GUP;
              else                       mode_d = MODE_GDOWN;
            end else begin
              case (in_test)
                TST_ADD:   mode_d = MODE_ADD;
                TST_RET:   mode_d = MODE_RET;
                TST_GUP:   mode_d = MODE_GUP;
                TST_GDOWN: mode_d = MODE_GDOWN;
                default:   mode_d = MODE_IDLE;
              endcase
            end
          end
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        // Hold the step while the previous item still waits
        if (uw.op == UOP_NOP) begin
          done = 1'b1;
        end else if (fin) begin
          done = uw.last;
        end else begin
          done = 1'b1;
        end
        if (!done || !otvalid_q || m_axis_tready) begin
          if (uw.op != UOP_NOP) begin
            valve_d = v_n;
            motor_d = m_n;
            stage_d = !fin;
            if (fin) begin
              if (uw.last) begin
                mode_d = MODE_IDLE;
                if (uw.clr_step) step_d = 3'd0;
              end else begin
                step_d = step_q + 3'd1;
              end
            end
          end
          if (done) begin
            odata_d   = {4'd0, step_d, mode_d, motor_d, valve_d};
            otvalid_d = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_IDLE;
      step_q    <= 3'd0;
      stage_q   <= 1'b0;
      lim_q     <= 3'd0;
      sen_q     <= 4'd0;
      valve_q   <= 4'd0;
      motor_q   <= MOT_STOP;
      kstart_q  <= 1'b0;
      otvalid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      step_q    <= step_d;
      stage_q   <= stage_d;
      lim_q     <= lim_d;
      sen_q     <= sen_d;
      valve_q   <= valve_d;
      motor_q   <= motor_d;
      kstart_q  <= kstart_d;
      otvalid_q <= otvalid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = otvalid_q;
  assign m_axis_tdata  = odata_q;

endmodule
